FILE: hw/rtl/slr_pkg.sv
// Shared codes for the table-driven shift-reduce recognizer.
// Command codes, action kinds and verdict codes; no dependencies.
`timescale 1ns / 1ps
package slr_pkg;

  // command codes carried by func
  localparam logic [2:0] FUNC_SYMBOL    = 3'd0;
  localparam logic [2:0] FUNC_END       = 3'd1;
  localparam logic [2:0] FUNC_WR_ACTION = 3'd2;
  localparam logic [2:0] FUNC_WR_GOTO   = 3'd3;
  localparam logic [2:0] FUNC_WR_PROD   = 3'd4;

  // action kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SHIFT  = 2'd1;
  localparam logic [1:0] KIND_REDUCE = 2'd2;
  localparam logic [1:0] KIND_ACCEPT = 2'd3;

  // verdict codes
  localparam logic [1:0] VERDICT_REJECT   = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPT   = 2'd1;
  localparam logic [1:0] VERDICT_OVERFLOW = 2'd2;

  // end marker fed by the end word
  localparam logic [7:0] END_MARK = 8'h24;

endpackage

FILE: hw/rtl/slr_shift_reduce_parser.sv
// Table-driven shift-reduce recognizer: one word at a time, every step of a
// parse run through a single sequencer over the action, goto, production and
// stack memories.  Table writes, blank symbols and ignored words are taken in
// the idle state.  After reset a clearing pass zeroes the action and goto
// tables, one entry at a time, with cmd_stall high.  A symbol that is shifted,
// accepted or rejected at once goes through accept, action read, decode and
// finish, and each reduce step goes through action read, production read,
// stack read, goto read and push; each step waits on a registered memory read.
// An end word drives the end marker and then byte 0 until a verdict is reached,
// then posts the verdict (directly if the verdict was already reached), later
// while the previous verdict word is stalled.
// Depends on slr_pkg.
`timescale 1ns / 1ps
module slr_shift_reduce_parser #(
  parameter int STATES      = 64,
  parameter int PRODUCTIONS = 64,
  parameter int STACK_DEPTH = 64,
  parameter int MAX_RHS     = 15
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [2:0] func,
  input  logic [7:0] symbol,
  input  logic [5:0] row_state,
  input  logic [1:0] entry_kind,
  input  logic [5:0] entry_value,
  input  logic [5:0] prod_number,
  input  logic [7:0] prod_left,
  input  logic [3:0] prod_length,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] verdict
);
  import slr_pkg::*;

  localparam int SW     = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int AW     = SW + 8;
  localparam int ADEPTH = STATES * 256;
  localparam int PW     = (PRODUCTIONS > 1) ? $clog2(PRODUCTIONS) : 1;
  localparam int DW     = $clog2(STACK_DEPTH);
  localparam int LW     = $clog2(STACK_DEPTH + 1);
  localparam int RLIMIT = STACK_DEPTH * STATES;
  localparam int CW     = $clog2(RLIMIT + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ACT_RD, S_ACT, S_PROD, S_POP, S_GOTO, S_FIN, S_DONE
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr_cnt;
  logic [5:0]      top;
  logic [7:0]      sym;
  logic [LW-1:0]   level;
  logic [CW-1:0]   steps;
  logic            decided;
  logic [1:0]      held_verdict;
  logic            end_mode;

  // memories
  logic [7:0]      action_mem [ADEPTH];
  logic [6:0]      goto_mem   [ADEPTH];
  logic [11:0]     prod_mem   [PRODUCTIONS];
  logic [5:0]      stack_mem  [STACK_DEPTH];
  logic [7:0]      act_q;
  logic [6:0]      goto_q;
  logic [11:0]     prod_q;
  logic [5:0]      stk_q;

  logic            accept;
  logic            blank;
  logic [1:0]      act_kind;
  logic [5:0]      act_val;
  logic [7:0]      p_left;
  logic [3:0]      p_len;
  logic [LW-1:0]   pop_level;
  logic            pop_empty;
  logic            full;
  logic            push_en;
  logic [5:0]      push_val;
  logic [3:0]      len_sat;
  logic            out_free;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign blank     = (symbol == 8'h20) || (symbol >= 8'h09 && symbol <= 8'h0d);
  assign act_kind  = act_q[7:6];
  assign act_val   = act_q[5:0];
  assign p_left    = prod_q[11:4];
  assign p_len     = prod_q[3:0];
  assign pop_empty = (16'(p_len) >= 16'(level));
  assign pop_level = level - LW'(p_len);
  assign full      = (32'(level) >= STACK_DEPTH);
  assign len_sat   = (32'(prod_length) > MAX_RHS) ? 4'(MAX_RHS) : prod_length;
  assign out_free  = !res_valid || !res_stall;

  // pick a push: shift target or goto target
  always_comb begin
    push_en  = 1'b0;
    push_val = act_val;
    if (state == S_ACT && act_kind == KIND_SHIFT) begin
      push_en = 1'b1;
    end else if (state == S_GOTO && goto_q[6]) begin
      push_en  = 1'b1;
      push_val = goto_q[5:0];
    end
  end

  // action and goto tables: clearing pass or table write, read at the parse address
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      action_mem[clr_cnt] <= 8'd0;
      goto_mem[clr_cnt]   <= 7'd0;
    end else if (accept && func == FUNC_WR_ACTION && 32'(row_state) < STATES) begin
      action_mem[AW'({row_state, symbol})] <= {entry_kind, entry_value};
    end else if (accept && func == FUNC_WR_GOTO && 32'(row_state) < STATES) begin
      goto_mem[AW'({row_state, symbol})] <= {1'b1, entry_value};
    end
    act_q  <= action_mem[AW'({top, sym})];
    goto_q <= goto_mem[AW'({stk_q, p_left})];
  end

  // production table
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_WR_PROD && 32'(prod_number) < PRODUCTIONS) begin
      prod_mem[PW'(prod_number)] <= {prod_left, len_sat};
    end
    prod_q <= prod_mem[PW'(act_val)];
  end

  // state stack: bottom entry set during clearing, pushes above it
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      stack_mem[0] <= 6'd0;
    end else if (push_en && !full) begin
      stack_mem[DW'(level)] <= push_val;
    end
    stk_q <= stack_mem[DW'(pop_level - LW'(1))];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      top          <= 6'd0;
      level        <= LW'(1);
      steps        <= '0;
      decided      <= 1'b0;
      held_verdict <= VERDICT_REJECT;
      end_mode     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_DONE) res_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(ADEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            steps <= '0;
            if (func == FUNC_SYMBOL && !decided && !blank) begin
              sym   <= symbol;
              state <= S_ACT_RD;
            end else if (func == FUNC_END) begin
              if (decided) begin
                state <= S_DONE;
              end else begin
                sym      <= END_MARK;
                end_mode <= 1'b1;
                state    <= S_ACT_RD;
              end
            end
          end
        end
        S_ACT_RD: begin
          if (32'(top) >= STATES) begin
            decided      <= 1'b1;
            held_verdict <= VERDICT_REJECT;
            state        <= S_FIN;
          end else begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          case (act_kind)
            KIND_NONE: begin
              decided      <= 1'b1;
              held_verdict <= VERDICT_REJECT;
              state        <= S_FIN;
            end
            KIND_ACCEPT: begin
              decided      <= 1'b1;
              held_verdict <= VERDICT_ACCEPT;
              state        <= S_FIN;
            end
            KIND_SHIFT: begin
              if (full) begin
                decided      <= 1'b1;
                held_verdict <= VERDICT_OVERFLOW;
              end else begin
                level <= level + LW'(1);
                top   <= act_val;
              end
              state <= S_FIN;
            end
            default: begin
              steps <= steps + CW'(1);
              if (32'(steps) >= RLIMIT || 32'(act_val) >= PRODUCTIONS) begin
                decided      <= 1'b1;
                held_verdict <= VERDICT_REJECT;
                state        <= S_FIN;
              end else begin
                state <= S_PROD;
              end
            end
          endcase
        end
        S_PROD: begin
          if (pop_empty) begin
            decided      <= 1'b1;
            held_verdict <= VERDICT_REJECT;
            state        <= S_FIN;
          end else begin
            level <= pop_level;
            state <= S_POP;
          end
        end
        S_POP: begin
          if (32'(stk_q) >= STATES) begin
            decided      <= 1'b1;
            held_verdict <= VERDICT_REJECT;
            state        <= S_FIN;
          end else begin
            state <= S_GOTO;
          end
        end
        S_GOTO: begin
          if (!goto_q[6]) begin
            decided      <= 1'b1;
            held_verdict <= VERDICT_REJECT;
            state        <= S_FIN;
          end else if (full) begin
            decided      <= 1'b1;
            held_verdict <= VERDICT_OVERFLOW;
            state        <= S_FIN;
          end else begin
            level <= level + LW'(1);
            top   <= goto_q[5:0];
            state <= S_ACT_RD;
          end
        end
        S_FIN: begin
          // end word keeps feeding byte 0 until a verdict
          if (!end_mode) begin
            state <= S_IDLE;
          end else if (decided) begin
            state <= S_DONE;
          end else begin
            sym   <= 8'd0;
            steps <= '0;
            state <= S_ACT_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_valid    <= 1'b1;
            verdict      <= held_verdict;
            top          <= 6'd0;
            level        <= LW'(1);
            decided      <= 1'b0;
            held_verdict <= VERDICT_REJECT;
            end_mode     <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/slr_checker.sv
// Port-level checks for the shift-reduce recognizer, bound to its top level.
// Depends on slr_pkg.
`timescale 1ns / 1ps
module slr_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_stall,
  input logic [2:0] func,
  input logic       res_valid,
  input logic       res_stall,
  input logic [1:0] verdict
);
  import slr_pkg::*;

  // no verdict code beyond overflow
  a_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (verdict == VERDICT_REJECT || verdict == VERDICT_ACCEPT ||
                   verdict == VERDICT_OVERFLOW))
    else $error("bad verdict code");

  // clearing pass holds off words after reset
  a_clear: assert property (@(posedge clk) rst |=> cmd_stall)
    else $error("word taken during clearing");

  // reset leaves no result pending
  a_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result after reset");

  // a non-end word never raises a result on the next cycle by itself
  a_only_end: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && func != FUNC_END && !res_valid) |=> !res_valid)
    else $error("result without end word");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(verdict)))
    else $error("stalled result changed");

endmodule

bind slr_shift_reduce_parser slr_checker u_slr_checker (
  .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .func(func),
  .res_valid(res_valid), .res_stall(res_stall), .verdict(verdict)
);

FILE: tb/tb_slr_shift_reduce_parser.sv
// Self-checking testbench for the table-driven shift-reduce recognizer.
// Predicts each verdict from its own copy of the tables and stack; needs slr_pkg.
`timescale 1ns / 1ps
module tb_slr_shift_reduce_parser;
  import slr_pkg::*;

  localparam int NSTATE   = 64;
  localparam int NPROD    = 64;
  localparam int DEPTH    = 64;
  localparam int RED_CAP  = DEPTH * NSTATE;
  localparam int N_WORDS  = 1750;

  logic       clk = 1'b0;
  logic       rst;
  logic       cmd_valid;
  logic       cmd_stall;
  logic [2:0] func;
  logic [7:0] symbol;
  logic [5:0] row_state;
  logic [1:0] entry_kind;
  logic [5:0] entry_value;
  logic [5:0] prod_number;
  logic [7:0] prod_left;
  logic [3:0] prod_length;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [1:0] verdict;

  slr_shift_reduce_parser dut (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .func(func), .symbol(symbol), .row_state(row_state), .entry_kind(entry_kind),
    .entry_value(entry_value), .prod_number(prod_number), .prod_left(prod_left),
    .prod_length(prod_length), .res_valid(res_valid), .res_stall(res_stall),
    .verdict(verdict)
  );

  always #6 clk = ~clk;

  // shadow parser state
  logic [1:0] act_kind [NSTATE][256];
  logic [5:0] act_val  [NSTATE][256];
  bit         goto_ok  [NSTATE][256];
  logic [5:0] goto_st  [NSTATE][256];
  logic [7:0] prod_lhs [NPROD];
  logic [3:0] prod_len [NPROD];
  logic [5:0] shadow_stack [DEPTH];
  int         shadow_level;
  bit         shadow_done;
  logic [1:0] shadow_verdict;

  logic [1:0] verdict_q[$];
  int         n_sent;
  int         n_errors;
  int         burst_left;
  int         stall_mode = 0;
  int         stall_timer = 0;

  function automatic void parse_restart();
    foreach (shadow_stack[i]) shadow_stack[i] = '0;
    shadow_level   = 1;
    shadow_done    = 1'b0;
    shadow_verdict = VERDICT_REJECT;
  endfunction

  function automatic void parse_settle(logic [1:0] v);
    shadow_done    = 1'b1;
    shadow_verdict = v;
  endfunction

  function automatic void parse_push(logic [5:0] s);
    if (shadow_level >= DEPTH) begin
      parse_settle(VERDICT_OVERFLOW);
    end else begin
      shadow_stack[shadow_level] = s;
      shadow_level++;
    end
  endfunction

  // run reduce steps for one symbol until shift, accept or reject
  function automatic void parse_feed(logic [7:0] sym);
    int         steps;
    logic [5:0] s;
    logic [5:0] t;
    logic [5:0] pv;
    steps = 0;
    forever begin
      s = shadow_stack[shadow_level - 1];
      pv = act_val[s][sym];
      case (act_kind[s][sym])
        KIND_NONE: begin
          parse_settle(VERDICT_REJECT);
          return;
        end
        KIND_ACCEPT: begin
          parse_settle(VERDICT_ACCEPT);
          return;
        end
        KIND_SHIFT: begin
          parse_push(pv);
          return;
        end
        default: begin
          if (steps >= RED_CAP) begin
            parse_settle(VERDICT_REJECT);
            return;
          end
          steps++;
          if (int'(prod_len[pv]) >= shadow_level) begin
            parse_settle(VERDICT_REJECT);
            return;
          end
          shadow_level -= prod_len[pv];
          t = shadow_stack[shadow_level - 1];
          if (!goto_ok[t][prod_lhs[pv]]) begin
            parse_settle(VERDICT_REJECT);
            return;
          end
          parse_push(goto_st[t][prod_lhs[pv]]);
          if (shadow_done) return;
        end
      endcase
    end
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // apply one word to the shadow state, queue any verdict it yields
  function automatic void parse_apply(logic [2:0] f, logic [7:0] sy, logic [5:0] rw,
                                      logic [1:0] k, logic [5:0] v, logic [5:0] pn,
                                      logic [7:0] pl, logic [3:0] plen);
    case (f)
      FUNC_SYMBOL: if (!shadow_done && !is_blank(sy)) parse_feed(sy);
      FUNC_END: begin
        if (!shadow_done) begin
          parse_feed(END_MARK);
          while (!shadow_done) parse_feed(8'h00);
        end
        verdict_q = {verdict_q, shadow_verdict};
        parse_restart();
      end
      FUNC_WR_ACTION: begin
        act_kind[rw][sy] = k;
        act_val[rw][sy]  = v;
      end
      FUNC_WR_GOTO: begin
        goto_ok[rw][sy] = 1'b1;
        goto_st[rw][sy] = v;
      end
      FUNC_WR_PROD: begin
        prod_lhs[pn] = pl;
        prod_len[pn] = plen;
      end
      default: ;
    endcase
  endfunction

  // send one word, idling in bursts with gaps
  task automatic send_word(logic [2:0] f, logic [7:0] sy, logic [5:0] rw, logic [1:0] k,
                           logic [5:0] v, logic [5:0] pn, logic [7:0] pl, logic [3:0] plen);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    cmd_valid   <= 1'b1;
    func        <= f;
    symbol      <= sy;
    row_state   <= rw;
    entry_kind  <= k;
    entry_value <= v;
    prod_number <= pn;
    prod_left   <= pl;
    prod_length <= plen;
    parse_apply(f, sy, rw, k, v, pn, pl, plen);
    do @(posedge clk); while (cmd_stall);
    n_sent++;
    burst_left--;
    if (burst_left == 0) cmd_valid <= 1'b0;
  endtask

  task automatic put_action(logic [5:0] rw, logic [7:0] sy, logic [1:0] k, logic [5:0] v);
    send_word(FUNC_WR_ACTION, sy, rw, k, v, 6'($urandom), 8'($urandom), 4'($urandom));
  endtask

  task automatic put_goto(logic [5:0] rw, logic [7:0] sy, logic [5:0] v);
    send_word(FUNC_WR_GOTO, sy, rw, 2'($urandom), v, 6'($urandom), 8'($urandom),
              4'($urandom));
  endtask

  task automatic put_prod(logic [5:0] pn, logic [7:0] pl, logic [3:0] plen);
    send_word(FUNC_WR_PROD, 8'($urandom), 6'($urandom), 2'($urandom), 6'($urandom), pn, pl,
              plen);
  endtask

  task automatic put_sym(logic [7:0] sy);
    send_word(FUNC_SYMBOL, sy, 6'($urandom), 2'($urandom), 6'($urandom), 6'($urandom),
              8'($urandom), 4'($urandom));
  endtask

  task automatic put_end();
    send_word(FUNC_END, 8'($urandom), 6'($urandom), 2'($urandom), 6'($urandom),
              6'($urandom), 8'($urandom), 4'($urandom));
  endtask

  task automatic put_string(string s);
    for (int i = 0; i < s.len(); i++) put_sym(s[i]);
    put_end();
  endtask

  // hold the sender until every verdict has come
  task automatic drain();
    if (burst_left != 0) begin
      cmd_valid  <= 1'b0;
      burst_left = 0;
    end
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // E -> E + n | n, plus whitespace and malformed strings
  task automatic test_expression_grammar();
    put_prod(6'd0, "E", 4'd3);
    put_prod(6'd1, "E", 4'd1);
    put_action(6'd0, "n", KIND_SHIFT, 6'd2);
    put_goto(6'd0, "E", 6'd1);
    put_action(6'd1, "+", KIND_SHIFT, 6'd3);
    put_action(6'd1, "$", KIND_ACCEPT, 6'd0);
    put_action(6'd2, "+", KIND_REDUCE, 6'd1);
    put_action(6'd2, "$", KIND_REDUCE, 6'd1);
    put_action(6'd3, "n", KIND_SHIFT, 6'd4);
    put_action(6'd4, "+", KIND_REDUCE, 6'd0);
    put_action(6'd4, "$", KIND_REDUCE, 6'd0);
    put_string("n+n");
    put_string("n\t+ n\n");
    put_string("n+");
    put_string("+n");
    put_string("");
    send_word(3'd5, 8'hFF, 6'h3F, 2'd3, 6'h3F, 6'h3F, 8'hFF, 4'hF);
    send_word(3'd7, 8'h00, 6'h00, 2'd0, 6'h00, 6'h00, 8'h00, 4'h0);
    drain();
  endtask

  // full stack, shifted end marker, emptied stack, endless reductions
  task automatic test_stack_limits();
    put_action(6'd0, "o", KIND_SHIFT, 6'd0);
    for (int i = 0; i < DEPTH + 2; i++) put_sym("o");
    put_end();
    put_action(6'd0, "$", KIND_SHIFT, 6'd5);
    put_action(6'd5, 8'h00, KIND_SHIFT, 6'd5);
    put_end();
    put_action(6'd0, "x", KIND_REDUCE, 6'd1);
    put_string("x");
    put_prod(6'd3, "Y", 4'd1);
    put_action(6'd0, "y", KIND_SHIFT, 6'd7);
    put_action(6'd7, "y", KIND_REDUCE, 6'd3);
    put_goto(6'd0, "Y", 6'd7);
    put_string("yy");
    drain();
  endtask

  function automatic logic [7:0] pick_sym();
    int r;
    r = $urandom_range(0, 19);
    if (r < 5) return "a";
    if (r < 10) return "b";
    if (r < 13) return "c";
    if (r < 15) return "$";
    if (r == 15) return 8'h00;
    if (r == 16) return ($urandom_range(0, 1) != 0) ? 8'h20 : 8'($urandom_range(9, 13));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_lhs();
    return ($urandom_range(0, 1) != 0) ? "S" : "T";
  endfunction

  // random small grammars over a few states, strings drawn mostly from their alphabet
  task automatic test_random_grammars();
    int r;
    for (int p = 0; p < NPROD; p++) put_prod(6'(p), pick_lhs(), 4'($urandom_range(0, 3)));
    while (n_sent < N_WORDS) begin
      repeat ($urandom_range(6, 16)) begin
        r = $urandom_range(0, 19);
        if (r < 9) begin
          r = $urandom_range(0, 19);
          put_action(6'($urandom_range(0, 7)), pick_sym(),
                     r < 8 ? KIND_SHIFT : r < 15 ? KIND_REDUCE : r < 17 ? KIND_ACCEPT : KIND_NONE,
                     6'($urandom_range(0, 7)));
        end else if (r < 15) begin
          put_goto(6'($urandom_range(0, 7)), pick_lhs(), 6'($urandom_range(0, 7)));
        end else if (r < 17) begin
          put_prod(6'($urandom_range(0, 7)), pick_lhs(), 4'($urandom_range(0, 3)));
        end else if (r == 17) begin
          send_word(FUNC_WR_ACTION + 3'($urandom_range(0, 2)), 8'($urandom), 6'($urandom),
                    2'($urandom), 6'($urandom), 6'($urandom), 8'($urandom), 4'($urandom));
        end else begin
          send_word(3'($urandom_range(5, 7)), 8'($urandom), 6'($urandom), 2'($urandom),
                    6'($urandom), 6'($urandom), 8'($urandom), 4'($urandom));
        end
      end
      repeat ($urandom_range(3, 8)) begin
        repeat ($urandom_range(0, 10)) put_sym(pick_sym());
        put_end();
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
  endtask

  // receiver stall pattern: free runs, random stalls, long holds
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  <= $urandom_range(0, 2);
      stall_timer <= $urandom_range(50, 300);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 2) == 0);
      default: res_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // compare each verdict word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (verdict_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected verdict word %0d at %0t", verdict, $realtime);
      end else if (verdict !== verdict_q[0]) begin
        n_errors++;
        if (n_errors <= 10)
          $display("verdict mismatch: expected %0d, got %0d at %0t", verdict_q[0], verdict,
                   $realtime);
        void'(verdict_q.pop_front());
      end else begin
        void'(verdict_q.pop_front());
      end
    end
  end

  initial begin
    #(64'd3_000_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    foreach (act_kind[i, j]) begin
      act_kind[i][j] = KIND_NONE;
      act_val[i][j]  = '0;
      goto_ok[i][j]  = 1'b0;
      goto_st[i][j]  = '0;
    end
    foreach (prod_lhs[i]) begin
      prod_lhs[i] = '0;
      prod_len[i] = '0;
    end
    parse_restart();
    n_sent      = 0;
    n_errors    = 0;
    burst_left  = 0;
    rst         <= 1'b1;
    cmd_valid   <= 1'b0;
    func        <= FUNC_SYMBOL;
    symbol      <= '0;
    row_state   <= '0;
    entry_kind  <= KIND_NONE;
    entry_value <= '0;
    prod_number <= '0;
    prod_left   <= '0;
    prod_length <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_expression_grammar();
    test_stack_limits();
    test_random_grammars();
    repeat (50) @(posedge clk);
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
